[rtl/serial_midi_message_parser_macros.svh]
// Assertion macros used by the checker file of the MIDI parser.
`ifndef SERIAL_MIDI_MESSAGE_PARSER_MACROS_SVH
`define SERIAL_MIDI_MESSAGE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMMP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("serial_midi_message_parser: check failed");

// The consequent must hold in the cycle after the antecedent.
`define SMMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("serial_midi_message_parser: check failed");

`endif

[rtl/smmp_pkg.sv]
package smmp_pkg;

  // Event kinds reported on the result channel.
  typedef enum logic [1:0] {
    KIND_NOTE_OFF = 2'd0,
    KIND_NOTE_ON  = 2'd1,
    KIND_CONTROL  = 2'd2
  } kind_e;

  // Status byte classification.
  localparam logic [7:0] NOTE_STATUS_MASK = 8'hE0;
  localparam logic [7:0] NOTE_STATUS      = 8'h80;
  localparam logic [7:0] TYPE_MASK        = 8'hF0;
  localparam logic [7:0] CONTROL_STATUS   = 8'hB0;
  localparam logic [3:0] TYPE_NOTE_ON     = 4'h9;
  localparam logic [3:0] TYPE_CONTROL     = 4'hB;

  // Stream widths.
  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 24;
  localparam int unsigned OutTuserW = 2;

  // One decoded channel message.
  typedef struct packed {
    kind_e      kind;
    logic [3:0] channel;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } event_t;

endpackage

[rtl/smmp_skid.sv]
module smmp_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  smmp_pkg::event_t  in_event_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output smmp_pkg::event_t  out_event_o
);

  logic             out_valid_q;
  logic             skid_valid_q;
  smmp_pkg::event_t out_event_q;
  smmp_pkg::event_t skid_event_q;

  // The upstream side only stalls when the spare slot is occupied.
  assign in_ready_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_event_o = out_event_q;

  // Control: output slot and spare slot occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_valid_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_event_q <= skid_event_q;
      end else if (in_valid_i) begin
        out_event_q <= in_event_i;
      end
    end else if (in_valid_i && !skid_valid_q) begin
      skid_event_q <= in_event_i;
    end
  end

endmodule

[rtl/serial_midi_message_parser.sv]
// Serial MIDI channel message parser.
// Input stream: one received MIDI byte per beat on s_axis_tdata_i[7:0].
// Output stream: one beat per complete note off, note on or control change
// message; tuser carries the event kind, tdata the channel and data bytes.
// Status bytes of other types and stray data bytes produce no beat. A status
// byte arriving where a data byte is expected drops the partial message and
// is decoded as a new status byte. Running status is not supported.
// The result beat is registered from the second data byte, or waits in the
// spare slot while the receiver stalls. Throughput: one input beat per cycle
// while s_axis_tready_o is high; the byte decode is a short path of compare
// and select logic ahead of the result register. A two-slot output buffer
// decouples the channels: when the receiver stalls, the block keeps taking
// bytes until a second result is pending, and only then drops s_axis_tready_o.
// Reset clears the parser to waiting for a status byte and empties the output.
module serial_midi_message_parser (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] midi_byte
  input  logic [smmp_pkg::InTdataW-1:0]       s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [3:0] channel, [10:4] first_data, [17:11] second_data, [23:18] zero
  output logic [smmp_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  // [1:0] event_kind
  output logic [smmp_pkg::OutTuserW-1:0]      m_axis_tuser_o
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] channel_q, channel_d;
  logic       is_control_q, is_control_d;
  logic       is_note_on_q, is_note_on_d;
  logic [6:0] first_q, first_d;

  logic             in_fire;
  logic             in_ready;
  logic [7:0]       byte_in;
  logic             status_ok;
  logic             ev_valid;
  smmp_pkg::event_t ev;
  smmp_pkg::event_t out_event;

  assign byte_in  = s_axis_tdata_i;
  assign in_fire  = s_axis_tvalid_i && in_ready;
  assign s_axis_tready_o = in_ready;

  // Status bytes worth tracking: note off, note on, control change.
  assign status_ok = ((byte_in & smmp_pkg::NOTE_STATUS_MASK) == smmp_pkg::NOTE_STATUS) ||
                     ((byte_in & smmp_pkg::TYPE_MASK) == smmp_pkg::CONTROL_STATUS);

  // Parser next state and event decode.
  always_comb begin
    phase_d      = phase_q;
    channel_d    = channel_q;
    is_control_d = is_control_q;
    is_note_on_d = is_note_on_q;
    first_d      = first_q;
    ev_valid     = 1'b0;
    if (in_fire) begin
      case (phase_q)
        PH_FIRST: begin
          if (!byte_in[7]) begin
            first_d = byte_in[6:0];
            phase_d = PH_SECOND;
          end else begin
            phase_d = status_ok ? PH_FIRST : PH_IDLE;
          end
        end
        PH_SECOND: begin
          if (!byte_in[7]) begin
            ev_valid = 1'b1;
            phase_d  = PH_IDLE;
          end else begin
            phase_d = status_ok ? PH_FIRST : PH_IDLE;
          end
        end
        default: begin
          phase_d = status_ok ? PH_FIRST : PH_IDLE;
        end
      endcase
      // Any accepted note off, note on or control change status byte becomes the held status.
      if (byte_in[7] && status_ok) begin
        channel_d    = byte_in[3:0];
        is_control_d = (byte_in[7:4] == smmp_pkg::TYPE_CONTROL);
        is_note_on_d = (byte_in[7:4] == smmp_pkg::TYPE_NOTE_ON);
      end
    end
  end

  // Event fields; a note on with zero velocity counts as note off.
  always_comb begin
    ev.channel     = channel_q;
    ev.first_data  = first_q;
    ev.second_data = byte_in[6:0];
    if (is_control_q) begin
      ev.kind = smmp_pkg::KIND_CONTROL;
    end else if (is_note_on_q && (byte_in[6:0] != 7'd0)) begin
      ev.kind = smmp_pkg::KIND_NOTE_ON;
    end else begin
      ev.kind = smmp_pkg::KIND_NOTE_OFF;
    end
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      channel_q    <= 4'd0;
      is_control_q <= 1'b0;
      is_note_on_q <= 1'b0;
      first_q      <= 7'd0;
    end else begin
      phase_q      <= phase_d;
      channel_q    <= channel_d;
      is_control_q <= is_control_d;
      is_note_on_q <= is_note_on_d;
      first_q      <= first_d;
    end
  end

  // Result register with a spare slot.
  smmp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ev_valid),
    .in_ready_o  (in_ready),
    .in_event_i  (ev),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_event_o (out_event)
  );

  assign m_axis_tdata_o = {6'd0, out_event.second_data, out_event.first_data,
                           out_event.channel};
  assign m_axis_tuser_o = out_event.kind;

endmodule

[rtl/smmp_checker.sv]
`include "serial_midi_message_parser_macros.svh"

module smmp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic [smmp_pkg::InTdataW-1:0]  s_axis_tdata_i,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [smmp_pkg::OutTdataW-1:0] m_axis_tdata_o,
  input logic [smmp_pkg::OutTuserW-1:0] m_axis_tuser_o
);

  logic in_fire;
  logic out_stall;
  logic out_idle;
  logic status_fire;
  logic note_on_out;
  logic [smmp_pkg::OutTuserW+smmp_pkg::OutTdataW-1:0] out_word;

  assign in_fire     = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_idle    = !m_axis_tvalid_o;
  assign status_fire = in_fire && s_axis_tdata_i[7];
  assign note_on_out = m_axis_tvalid_o && (m_axis_tuser_o == smmp_pkg::KIND_NOTE_ON);
  assign out_word    = {m_axis_tuser_o, m_axis_tdata_o};

  // A new result beat only follows an accepted input byte.
  `SMMP_ASSERT_NEXT(a_result_needs_input, clk_i, rst_ni, out_idle && !in_fire, out_idle)

  // A status byte never completes a message.
  `SMMP_ASSERT_NEXT(a_status_no_result, clk_i, rst_ni, out_idle && status_fire, out_idle)

  // A reported note on always carries a nonzero velocity.
  `SMMP_ASSERT_SAME(a_note_on_velocity, clk_i, rst_ni, note_on_out, m_axis_tdata_o[17:11] != 7'd0)

  // A stalled result beat holds its payload.
  `SMMP_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

endmodule

bind serial_midi_message_parser smmp_checker u_smmp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
